// ===== design/ssc_pkg.sv =====
// Shared types and constants of the stand sleep controller.
`default_nettype none
package ssc_pkg;

    // Power state codes carried in the state fields of the streams.
    localparam logic [2:0] ST_RUN        = 3'd0;
    localparam logic [2:0] ST_PRESTANDBY = 3'd1;
    localparam logic [2:0] ST_STANDBY    = 3'd2;
    localparam logic [2:0] ST_SLEEP      = 3'd3;
    localparam logic [2:0] ST_EMERGENCY  = 3'd4;
    localparam logic [2:0] ST_HALTED     = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SINGLE_PIN = 3'd0;
    localparam logic [2:0] REG_MOMENTARY  = 3'd1;
    localparam logic [2:0] REG_PRE_SEC    = 3'd2;
    localparam logic [2:0] REG_STBY_MIN   = 3'd3;
    localparam logic [2:0] REG_BUZZER     = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE   = 3'd5;

    // Time scale factors and the parked threshold (average >= 1/LEVEL_RATIO).
    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned MS_PER_MIN   = 60000;
    localparam int unsigned LEVEL_RATIO  = 5;

    // Reset values of the registers.
    localparam logic [9:0]  RST_STBY_MIN = 10'd10;
    localparam logic [15:0] RST_DEBOUNCE = 16'd100;

    localparam int unsigned PRE_MS_W  = 20;
    localparam int unsigned STBY_MS_W = 26;

    typedef struct packed {
        logic                 single_pin;
        logic                 momentary;
        logic [9:0]           pre_sec;
        logic [9:0]           stby_min;
        logic                 buzzer;
        logic [15:0]          debounce;
        logic [PRE_MS_W-1:0]  pre_ms;
        logic [STBY_MS_W-1:0] stby_ms;
    } t_cfg;

endpackage
`default_nettype wire

// ===== design/ssc_cfg_regs.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none
module ssc_cfg_regs
    import ssc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // The millisecond limits are formed at reset and when the register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.single_pin <= 1'b0;
            r_cfg.momentary  <= 1'b0;
            r_cfg.pre_sec    <= '0;
            r_cfg.stby_min   <= RST_STBY_MIN;
            r_cfg.buzzer     <= 1'b1;
            r_cfg.debounce   <= RST_DEBOUNCE;
            r_cfg.pre_ms     <= '0;
            r_cfg.stby_ms    <= STBY_MS_W'(RST_STBY_MIN) * STBY_MS_W'(MS_PER_MIN);
        end else if (wr_en) begin
            case (idx)
                REG_SINGLE_PIN: r_cfg.single_pin <= pwdata[0];
                REG_MOMENTARY:  r_cfg.momentary  <= pwdata[0];
                REG_PRE_SEC: begin
                    r_cfg.pre_sec <= pwdata[9:0];
                    r_cfg.pre_ms  <= PRE_MS_W'(pwdata[9:0]) * PRE_MS_W'(MS_PER_SEC);
                end
                REG_STBY_MIN: begin
                    r_cfg.stby_min <= pwdata[9:0];
                    r_cfg.stby_ms  <= STBY_MS_W'(pwdata[9:0]) * STBY_MS_W'(MS_PER_MIN);
                end
                REG_BUZZER:     r_cfg.buzzer   <= pwdata[0];
                REG_DEBOUNCE:   r_cfg.debounce <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SINGLE_PIN: prdata = {31'd0, r_cfg.single_pin};
            REG_MOMENTARY:  prdata = {31'd0, r_cfg.momentary};
            REG_PRE_SEC:    prdata = {22'd0, r_cfg.pre_sec};
            REG_STBY_MIN:   prdata = {22'd0, r_cfg.stby_min};
            REG_BUZZER:     prdata = {31'd0, r_cfg.buzzer};
            REG_DEBOUNCE:   prdata = {16'd0, r_cfg.debounce};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/ssc_window_ram.sv =====
// One-bit-wide sample memory with one write port and one registered read port.
`default_nettype none
module ssc_window_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic          i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic               o_rd_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== design/stand_sleep_controller.sv =====
// Stand sleep controller: handle-in-stand detection and power state stepping.
//
// Each input beat is one poll: a millisecond tick, two "pin reads low" bits
// and the current power state. Each poll yields exactly one output beat with
// the new power state, the parked flag and two beep request bits.
// Both streams use valid/ready; a beat moves when tvalid and tready are high.
//
// A poll is taken into an update stage while the sample memory reads the
// oldest window sample. The update stage adjusts the window sum, the debounce
// logic and the state timers, writes the new sample back in level mode and
// loads the output register, where the result beat waits until tready is high.
// A new poll is taken in every cycle while the output side keeps up. When the
// receiver stalls, the output register holds its beat, the update stage takes
// one more poll and holds it, and tready stays low until the output beat
// leaves. With a one-entry window the write of one poll and the read of the
// next hit the same entry, so the written bit is forwarded. Synchronous reset
// clears the control, detection and timer state; window entries not yet
// written since reset are masked until the write pointer has wrapped once, so
// the memory needs no clearing pass. Configuration is written by the user
// only while the block is idle; the block itself does not enforce it.
`default_nettype none
module stand_sleep_controller
    import ssc_pkg::*;
#(
    parameter int unsigned WINDOW = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB-style configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Poll stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] now_ms, [32] stand_pin_low, [33] second_pin_low, [36:34] state_in
    input  wire logic [39:0] s_axis_tdata,
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] state_out, [3] parked, [4] beep_single, [5] beep_twice
    output logic      [7:0]  m_axis_tdata
);

    localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SW = $clog2(WINDOW + 1);
    localparam int unsigned CW = SW + 3;
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

    t_cfg cfg;

    ssc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshakes of the two pipeline boundaries.
    logic s_accept;
    logic s1_fire;

    // Read stage: window pointer and wrap flag.
    logic [PW-1:0] r_pos;
    logic          r_full;

    // Update stage: the poll in flight.
    logic          r_s1_valid;
    logic [31:0]   r_s1_now;
    logic          r_s1_sp;
    logic          r_s1_hp;
    logic [2:0]    r_s1_st;
    logic [PW-1:0] r_s1_addr;
    logic          r_s1_old_valid;
    logic          r_s1_fwd;
    logic          r_s1_fwd_bit;

    // Persistent detection and timer state.
    logic [SW-1:0] r_sum;
    logic          r_last_raw;
    logic [31:0]   r_db_start;
    logic          r_settled;
    logic          r_toggle;
    logic [31:0]   r_pre_start;
    logic [31:0]   r_stby_start;

    // Output register.
    logic          r_o_valid;
    logic [7:0]    r_o_data;

    // Memory port signals.
    logic          wr_en;
    logic          rd_data;

    // Update-stage results.
    logic          sig;
    logic          old_bit;
    logic [SW-1:0] n_sum;
    logic          n_last_raw;
    logic [31:0]   n_db_start;
    logic          n_settled;
    logic          n_toggle;
    logic [31:0]   n_pre_start;
    logic [31:0]   n_stby_start;
    logic          parked;
    logic          beep1;
    logic          beep2;
    logic [2:0]    n_st;
    logic [31:0]   db_elapsed;
    logic [31:0]   pre_elapsed;
    logic [31:0]   stby_elapsed;
    logic          pre_done;
    logic          stby_done;
    logic          stby_zero;
    logic [CW-1:0] sum_x;

    assign s1_fire       = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s1_fire && !cfg.momentary;

    ssc_window_ram #(
        .DEPTH (WINDOW),
        .AW    (PW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (sig),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    always_comb begin
        sig = cfg.single_pin ? r_s1_sp : (r_s1_sp | r_s1_hp);

        // Oldest sample: forwarded from the write in the same cycle as the
        // read, else the memory word once the entry has been written.
        old_bit = r_s1_fwd ? r_s1_fwd_bit : (r_s1_old_valid & rd_data);

        n_sum        = r_sum;
        n_last_raw   = r_last_raw;
        n_db_start   = r_db_start;
        n_settled    = r_settled;
        n_toggle     = r_toggle;
        beep1        = 1'b0;
        beep2        = 1'b0;
        db_elapsed   = r_s1_now - r_db_start;
        sum_x        = '0;

        if (!cfg.momentary) begin
            n_sum    = r_sum - SW'(old_bit) + SW'(sig);
            sum_x    = (CW'(n_sum) << 2) + CW'(n_sum);
            n_toggle = (sum_x >= CW'(WINDOW));
        end else if (sig != r_last_raw) begin
            n_db_start = r_s1_now;
            n_last_raw = sig;
            n_settled  = 1'b0;
        end else if (!r_settled && (db_elapsed > 32'(cfg.debounce))) begin
            n_settled = 1'b1;
            if (sig) begin
                beep1    = cfg.buzzer & !r_toggle;
                beep2    = cfg.buzzer & r_toggle;
                n_toggle = !r_toggle;
            end
        end
        parked = n_toggle;

        // Power state transitions, with the chained steps folded in: a timer
        // started in this poll has zero elapsed time.
        pre_elapsed  = r_s1_now - r_pre_start;
        stby_elapsed = r_s1_now - r_stby_start;
        pre_done     = pre_elapsed >= 32'(cfg.pre_ms);
        stby_done    = stby_elapsed >= 32'(cfg.stby_ms);
        stby_zero    = (cfg.stby_ms == '0);
        n_pre_start  = r_pre_start;
        n_stby_start = r_stby_start;
        n_st         = r_s1_st;

        if (parked) begin
            case (r_s1_st)
                ST_RUN: begin
                    if (cfg.pre_sec != '0) begin
                        n_st        = ST_PRESTANDBY;
                        n_pre_start = r_s1_now;
                    end else begin
                        n_stby_start = r_s1_now;
                        n_st         = stby_zero ? ST_SLEEP : ST_STANDBY;
                    end
                end
                ST_PRESTANDBY: begin
                    if (pre_done) begin
                        n_stby_start = r_s1_now;
                        n_st         = stby_zero ? ST_SLEEP : ST_STANDBY;
                    end
                end
                ST_STANDBY: begin
                    if (stby_done) begin
                        n_st = ST_SLEEP;
                    end
                end
                ST_EMERGENCY, ST_HALTED: n_st = ST_SLEEP;
                default: ;
            endcase
        end else begin
            case (r_s1_st)
                ST_RUN, ST_PRESTANDBY, ST_STANDBY, ST_SLEEP: n_st = ST_RUN;
                default: ;
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_full       <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
            r_sum        <= '0;
            r_last_raw   <= 1'b0;
            r_db_start   <= '0;
            r_settled    <= 1'b0;
            r_toggle     <= 1'b0;
            r_pre_start  <= '0;
            r_stby_start <= '0;
        end else begin
            if (s_accept && !cfg.momentary) begin
                if (r_pos == POS_LAST) begin
                    r_pos  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end

            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_o_valid    <= 1'b1;
                r_sum        <= n_sum;
                r_last_raw   <= n_last_raw;
                r_db_start   <= n_db_start;
                r_settled    <= n_settled;
                r_toggle     <= n_toggle;
                r_pre_start  <= n_pre_start;
                r_stby_start <= n_stby_start;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_now       <= s_axis_tdata[31:0];
            r_s1_sp        <= s_axis_tdata[32];
            r_s1_hp        <= s_axis_tdata[33];
            r_s1_st        <= s_axis_tdata[36:34];
            r_s1_addr      <= r_pos;
            r_s1_old_valid <= r_full;
            r_s1_fwd       <= wr_en && (r_s1_addr == r_pos);
            r_s1_fwd_bit   <= sig;
        end
        if (s1_fire) begin
            r_o_data <= {2'b00, beep2, beep1, parked, n_st};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule
`default_nettype wire

// ===== tb/sv/tb_stand_sleep_controller.sv =====
// Self-checking stream testbench for the stand sleep controller.
`timescale 1ns / 1ps
module tb_stand_sleep_controller;
    import ssc_pkg::*;

    // Window length of the moving average and the parked threshold:
    // the handle counts as parked once PARK_RATIO * sum >= WIN.
    localparam int unsigned WIN          = 8;
    localparam int unsigned PARK_RATIO   = 5;
    localparam logic [31:0] SEC_MS       = 32'd1000;
    localparam logic [31:0] MIN_MS       = 32'd60000;
    // Idle cycles waited after the last owed result while draining.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_POLLS  = 140;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned LONG_HOLD    = 64;
    localparam int unsigned NUM_ROWS     = 27;

    // State codes that the block does not know; they must pass through.
    localparam logic [2:0] ST_BAD_6 = 3'd6;
    localparam logic [2:0] ST_BAD_7 = 3'd7;

    typedef struct packed {
        logic [31:0] now;
        logic        stand;
        logic        second;
        logic [2:0]  state;
    } t_poll;

    typedef struct packed {
        logic [2:0] state;
        logic       parked;
        logic       beep_single;
        logic       beep_twice;
    } t_poll_result;

    typedef enum logic { ROW_POLL, ROW_CFG } t_row_kind;

    // One row of the directed table. On a poll row, word is the millisecond
    // tick and reg_idx is unused; on a register row, word is the value and
    // the pin and state fields are unused. When chk is set, the expected
    // result is the one typed into the row.
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] word;
        logic        stand;
        logic        second;
        logic [2:0]  state;
        logic [2:0]  reg_idx;
        logic        chk;
        logic [2:0]  e_state;
        logic        e_parked;
        logic        e_single;
        logic        e_twice;
    } t_row;

    typedef struct packed {
        logic        single_pin;
        logic        momentary;
        logic [9:0]  pre_sec;
        logic [9:0]  stby_min;
        logic        buzzer;
        logic [15:0] debounce;
    } t_setting;

    // The directed table starts from the reset settings: level mode, both
    // pins sense presence, no prestandby, ten minutes of standby.
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // Empty window, then one sample: still below the threshold.
        '{ROW_POLL, 32'd0, 1'b0, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b1, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd10, 1'b1, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b1, ST_RUN, 1'b0, 1'b0, 1'b0},
        // The second pin alone counts; two samples park, run goes to standby.
        '{ROW_POLL, 32'd20, 1'b0, 1'b1, ST_RUN, REG_SINGLE_PIN,
          1'b1, ST_STANDBY, 1'b1, 1'b0, 1'b0},
        '{ROW_POLL, 32'd30, 1'b1, 1'b1, ST_EMERGENCY, REG_SINGLE_PIN,
          1'b1, ST_SLEEP, 1'b1, 1'b0, 1'b0},
        '{ROW_POLL, 32'd40, 1'b1, 1'b0, ST_HALTED, REG_SINGLE_PIN,
          1'b1, ST_SLEEP, 1'b1, 1'b0, 1'b0},
        // Standby one millisecond short of ten minutes, then exactly on it.
        '{ROW_POLL, 32'd600019, 1'b1, 1'b0, ST_STANDBY, REG_SINGLE_PIN,
          1'b1, ST_STANDBY, 1'b1, 1'b0, 1'b0},
        '{ROW_POLL, 32'd600020, 1'b1, 1'b0, ST_STANDBY, REG_SINGLE_PIN,
          1'b1, ST_SLEEP, 1'b1, 1'b0, 1'b0},
        // Unknown state codes pass through, at both ends of the tick.
        '{ROW_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_BAD_6, REG_SINGLE_PIN,
          1'b1, ST_BAD_6, 1'b1, 1'b0, 1'b0},
        '{ROW_POLL, 32'd0, 1'b0, 1'b0, ST_BAD_7, REG_SINGLE_PIN,
          1'b1, ST_BAD_7, 1'b1, 1'b0, 1'b0},
        // The window drains one sample per poll.
        '{ROW_POLL, 32'd5, 1'b0, 1'b0, ST_SLEEP, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd6, 1'b0, 1'b0, ST_PRESTANDBY, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd7, 1'b0, 1'b0, ST_EMERGENCY, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd8, 1'b0, 1'b0, ST_HALTED, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        // At the smallest parked sum, then just below it.
        '{ROW_POLL, 32'd9, 1'b0, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b1, ST_STANDBY, 1'b1, 1'b0, 1'b0},
        '{ROW_POLL, 32'd10, 1'b0, 1'b0, ST_SLEEP, REG_SINGLE_PIN,
          1'b1, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd11, 1'b0, 1'b0, ST_EMERGENCY, REG_SINGLE_PIN,
          1'b1, ST_EMERGENCY, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd12, 1'b0, 1'b0, ST_HALTED, REG_SINGLE_PIN,
          1'b1, ST_HALTED, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd13, 1'b0, 1'b0, ST_PRESTANDBY, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        // Switch to the stand pin alone, momentary mode, one second of
        // prestandby. The parked flag carries over from level mode.
        '{ROW_CFG, 32'd1, 1'b0, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, 32'd1, 1'b0, 1'b0, ST_RUN, REG_MOMENTARY,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, 32'd1, 1'b0, 1'b0, ST_RUN, REG_PRE_SEC,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        // Press, hold exactly the debounce time, then one more millisecond.
        '{ROW_POLL, 32'd1000, 1'b1, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd1100, 1'b1, 1'b1, ST_RUN, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'd1101, 1'b1, 1'b0, ST_RUN, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        // Release (the second pin is ignored now) as prestandby runs out.
        '{ROW_POLL, 32'd2101, 1'b0, 1'b1, ST_PRESTANDBY, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        // Press just before the tick wraps; it settles after the wrap.
        '{ROW_POLL, 32'hFFFF_FFF0, 1'b1, 1'b0, ST_STANDBY, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0},
        '{ROW_POLL, 32'h0000_0070, 1'b1, 1'b0, ST_SLEEP, REG_SINGLE_PIN,
          1'b0, ST_RUN, 1'b0, 1'b0, 1'b0}
    };

    // Register settings of the random phases, extremes among them. The
    // last phase runs without any idling.
    localparam t_setting PHASES [NUM_PHASES] = '{
        '{1'b0, 1'b0, 10'd0,   10'd0,   1'b1, 16'd100},
        '{1'b1, 1'b1, 10'd2,   10'd1,   1'b1, 16'd0},
        '{1'b0, 1'b1, 10'd999, 10'd999, 1'b0, 16'd65535},
        '{1'b1, 1'b0, 10'd1,   10'd2,   1'b1, 16'd20},
        '{1'b0, 1'b1, 10'd1,   10'd0,   1'b1, 16'd20},
        '{1'b0, 1'b0, 10'd5,   10'd1,   1'b0, 16'd1},
        '{1'b1, 1'b1, 10'd0,   10'd3,   1'b1, 16'd65535},
        '{1'b0, 1'b1, 10'd1,   10'd1,   1'b1, 16'd50}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] now_ms, [32] stand_pin_low, [33] second_pin_low, [36:34] state_in
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] state_out, [3] parked, [4] beep_single, [5] beep_twice
    logic [7:0]  m_axis_tdata;

    stand_sleep_controller #(
        .WINDOW(WIN)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Our copy of the register settings, written along with the block's.
    logic        cfg_single_pin = 1'b0;
    logic        cfg_momentary = 1'b0;
    logic [9:0]  cfg_pre_sec = 10'd0;
    logic [9:0]  cfg_stby_min = RST_STBY_MIN;
    logic        cfg_buzzer = 1'b1;
    logic [15:0] cfg_debounce = RST_DEBOUNCE;

    // Our copy of the detection and timer state, as it is after reset.
    logic [WIN-1:0] win_bits = '0;
    int unsigned    win_sum = 0;
    int unsigned    win_pos = 0;
    logic           last_sig = 1'b0;
    logic [31:0]    db_start = '0;
    logic           db_settled = 1'b0;
    logic           held_parked = 1'b0;
    logic [31:0]    pre_start = '0;
    logic [31:0]    stby_start = '0;
    logic [2:0]     prev_state_out = ST_RUN;

    // Results owed by the block, oldest first.
    t_poll_result pending_results[$];
    int unsigned  fail_count = 0;

    // Sender and receiver idling controls, and the request for one long
    // receiver hold-off that the receiver process counts out itself.
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    // Random tick and pin levels carried from one poll to the next.
    logic [31:0] gen_now = 32'hFFFF_0000;
    logic        gen_stand = 1'b0;
    logic        gen_second = 1'b0;

    // Works out the result of one poll and advances our copy of the state.
    // The transitions are taken in order, so a single poll can chain them.
    task automatic judge_poll(input t_poll p, output t_poll_result r);
        logic        sig;
        logic        parked;
        logic [2:0]  st;
        logic [31:0] elapsed;
        sig = cfg_single_pin ? p.stand : (p.stand | p.second);
        st = p.state;
        r = '0;
        if (!cfg_momentary) begin
            // Level mode: the oldest sample leaves the window, the new one
            // enters, and the parked flag tracks the level result.
            win_sum = win_sum + sig - win_bits[win_pos];
            win_bits[win_pos] = sig;
            win_pos = (win_pos + 1) % WIN;
            parked = (win_sum * PARK_RATIO >= WIN);
            held_parked = parked;
        end else begin
            // Momentary mode: any change restarts the debounce timer; once
            // the signal has held longer than the debounce time, a press
            // flips the parked flag and asks for a beep.
            elapsed = p.now - db_start;
            if (sig != last_sig) begin
                db_start = p.now;
                last_sig = sig;
                db_settled = 1'b0;
            end else if (!db_settled && elapsed > {16'd0, cfg_debounce}) begin
                db_settled = 1'b1;
                if (sig) begin
                    if (!held_parked) begin
                        r.beep_single = cfg_buzzer;
                    end else begin
                        r.beep_twice = cfg_buzzer;
                    end
                    held_parked = ~held_parked;
                end
            end
            parked = held_parked;
        end

        if (parked) begin
            if (st == ST_RUN) begin
                if (cfg_pre_sec != 10'd0) begin
                    st = ST_PRESTANDBY;
                    pre_start = p.now;
                end else begin
                    st = ST_STANDBY;
                    stby_start = p.now;
                end
            end
            elapsed = p.now - pre_start;
            if (st == ST_PRESTANDBY && elapsed >= 32'(cfg_pre_sec) * SEC_MS) begin
                st = ST_STANDBY;
                stby_start = p.now;
            end
            elapsed = p.now - stby_start;
            if (st == ST_STANDBY && elapsed >= 32'(cfg_stby_min) * MIN_MS) begin
                st = ST_SLEEP;
            end
            if (st == ST_EMERGENCY || st == ST_HALTED) begin
                st = ST_SLEEP;
            end
        end else if (st == ST_RUN || st == ST_PRESTANDBY || st == ST_STANDBY ||
                     st == ST_SLEEP) begin
            st = ST_RUN;
        end

        r.state = st;
        r.parked = parked;
        prev_state_out = st;
    endtask

    // Updates our copy of one register and returns what a read should give.
    function automatic logic [31:0] store_setting(input logic [2:0] idx,
                                                  input logic [31:0] val);
        case (idx)
            REG_SINGLE_PIN: begin
                cfg_single_pin = val[0];
                return {31'd0, val[0]};
            end
            REG_MOMENTARY: begin
                cfg_momentary = val[0];
                return {31'd0, val[0]};
            end
            REG_PRE_SEC: begin
                cfg_pre_sec = val[9:0];
                return {22'd0, val[9:0]};
            end
            REG_STBY_MIN: begin
                cfg_stby_min = val[9:0];
                return {22'd0, val[9:0]};
            end
            REG_BUZZER: begin
                cfg_buzzer = val[0];
                return {31'd0, val[0]};
            end
            REG_DEBOUNCE: begin
                cfg_debounce = val[15:0];
                return {16'd0, val[15:0]};
            end
            default: return 32'd0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Writes a register with a setup and an access cycle, then reads it back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] readback;
        logic [31:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        want = store_setting(idx, val);
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        check_field($sformatf("register %0d readback", idx), want, readback);
    endtask

    // Drops the poll stream and waits until every owed result is back, plus
    // a few cycles so the pipeline is surely empty.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offers one poll beat, maybe after an idle burst, and files the result
    // it owes once the block takes it. A typed result, where given, stands in
    // for the predicted one.
    task automatic send_poll(input t_poll p, input logic typed,
                             input t_poll_result typed_res);
        t_poll_result res;
        int unsigned  gap;
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, p.state, p.second, p.stand, p.now};
        do @(posedge i_clk); while (!s_axis_tready);
        judge_poll(p, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Random poll much like a control loop would send: the tick moves on by
    // mostly small steps with occasional long jumps and wraps, the pins hold
    // their level for several polls, and the state fed in is mostly the one
    // the block returned last. The rest is glitches and arbitrary states.
    function automatic t_poll make_poll();
        t_poll       p;
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            step = $urandom_range(1, 40);
        end else if (pick < 80) begin
            step = $urandom_range(41, 3000);
        end else if (pick < 94) begin
            step = $urandom_range(3001, 200000);
        end else if (pick < 98) begin
            step = $urandom_range(200001, 70000000);
        end else begin
            step = $urandom;
        end
        gen_now = gen_now + step;
        if ($urandom_range(0, 4) == 0) gen_stand = ~gen_stand;
        if ($urandom_range(0, 5) == 0) gen_second = ~gen_second;
        p.now = gen_now;
        if ($urandom_range(0, 19) == 0) begin
            p.stand = 1'($urandom_range(0, 1));
            p.second = 1'($urandom_range(0, 1));
        end else begin
            p.stand = gen_stand;
            p.second = gen_second;
        end
        if ($urandom_range(0, 99) < 85) begin
            p.state = prev_state_out;
        end else begin
            p.state = 3'($urandom_range(0, 7));
        end
        return p;
    endfunction

    // Receiver: random stall bursts, plus the one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every result beat is held against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_poll_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat 0x%02h with no poll owed", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("state_out", 32'(want.state), 32'(m_axis_tdata[2:0]));
                check_field("parked", 32'(want.parked), 32'(m_axis_tdata[3]));
                check_field("beep_single", 32'(want.beep_single),
                            32'(m_axis_tdata[4]));
                check_field("beep_twice", 32'(want.beep_twice),
                            32'(m_axis_tdata[5]));
            end
        end
    end

    initial begin : stimulus
        t_poll        p;
        t_poll_result typed_res;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: register rows wait for an idle block first.
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].word);
            end else begin
                p.now = DIRECTED[i].word;
                p.stand = DIRECTED[i].stand;
                p.second = DIRECTED[i].second;
                p.state = DIRECTED[i].state;
                typed_res.state = DIRECTED[i].e_state;
                typed_res.parked = DIRECTED[i].e_parked;
                typed_res.beep_single = DIRECTED[i].e_single;
                typed_res.beep_twice = DIRECTED[i].e_twice;
                send_poll(p, DIRECTED[i].chk, typed_res);
            end
        end

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph == NUM_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            write_reg(REG_SINGLE_PIN, {31'd0, PHASES[ph].single_pin});
            write_reg(REG_MOMENTARY, {31'd0, PHASES[ph].momentary});
            write_reg(REG_PRE_SEC, {22'd0, PHASES[ph].pre_sec});
            write_reg(REG_STBY_MIN, {22'd0, PHASES[ph].stby_min});
            write_reg(REG_BUZZER, {31'd0, PHASES[ph].buzzer});
            write_reg(REG_DEBOUNCE, {16'd0, PHASES[ph].debounce});
            for (int n = 0; n < PHASE_POLLS; n++) begin
                // Long receiver hold-off while polls keep coming, so the
                // block fills up and drops tready.
                if (ph == 3 && n == 30) hold_req = 1'b1;
                // The sender pauses until the block has answered everything.
                if (ph == 4 && n == 70) wait_drained();
                send_poll(make_poll(), 1'b0, '0);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("stand_sleep_controller regression: pass");
        end else begin
            $display("stand_sleep_controller regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $error("run did not finish, %0d results still owed", pending_results.size());
        $display("stand_sleep_controller regression: fail");
        $finish;
    end

endmodule
